// ===== hw/rtl/escd_pkg.sv =====
// Shared constants and register codes for the escaped stream channel demux.
`timescale 1ns / 1ps

package escd_pkg;

	// Largest chunk the store holds
	localparam int MAX_CHUNK_DEF = 64;

	// Field widths
	localparam int BYTE_W       = 8;
	localparam int CHUNK_SIZE_W = 7;
	localparam int CFG_IDX_W    = 2;

	// Bit flipped on the byte that follows an escape marker
	localparam logic [BYTE_W-1:0] ESC_FLIP = 8'(1 << 5);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MARKER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE     = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0]       CHANNEL_MARKER_RST = 8'd254;
	localparam logic [BYTE_W-1:0]       ESCAPE_MARKER_RST  = 8'd253;
	localparam logic [CHUNK_SIZE_W-1:0] CHUNK_SIZE_RST     = 7'd64;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== hw/rtl/escd_if.sv =====
// Handshake interfaces for the received stream, the chunk output and the register port.
`timescale 1ns / 1ps

interface escd_in_if;
	logic          valid;
	logic          ready;
	escd_pkg::byte_t in_byte;
	logic          end_of_payload;

	modport source (output valid, output in_byte, output end_of_payload, input ready);
	modport sink   (input valid, input in_byte, input end_of_payload, output ready);
endinterface

interface escd_out_if;
	logic          valid;
	logic          ready;
	escd_pkg::byte_t channel;
	escd_pkg::byte_t out_byte;
	logic          chunk_last;

	modport source (output valid, output channel, output out_byte, output chunk_last,
		input ready);
	modport sink   (input valid, input channel, input out_byte, input chunk_last,
		output ready);
endinterface

interface escd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [escd_pkg::CFG_IDX_W-1:0]     index;
	escd_pkg::byte_t                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/escd_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module escd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/escaped_stream_channel_demux.sv =====
// Top level of the escaped stream channel demux: decode, chunk store and flush sequencer.
`timescale 1ns / 1ps

// Usage
// - rx (sink): one received byte per word, with end_of_payload on the last
//   byte of a payload. A byte equal to the channel marker flushes the chunk
//   and makes the next data byte the channel number; a byte equal to the
//   escape marker makes the next non-marker byte flip bit 5.
// - tx (source): decoded bytes of a chunk, each tagged with the channel;
//   chunk_last marks the final byte of a chunk.
// - cfg (sink): register writes (channel marker, escape marker, chunk size),
//   always ready; write only while the block is idle.
// Timing
// - A byte that causes no flush is taken without a stall; rx.ready stays high.
// - A flush reads the chunk RAM one byte at a time: a read is issued, then
//   the output register is loaded from it; the next read waits for that load
//   and for a free output register. rx.ready stays low for the whole flush;
//   rx reopens as soon as the last byte sits in the output register.
// - The first flushed byte passes state_q, the RAM read and the output register.
// Reset clears the markers and chunk size to their defaults, drops any
// pending escape or channel select and empties the store; no clearing pass.
// While tx stalls, the flush holds: no RAM read is issued until the output
// register is free.

module escaped_stream_channel_demux #(
	parameter int MAX_CHUNK = escd_pkg::MAX_CHUNK_DEF
) (
	input  logic clk,
	input  logic arst_n,
	escd_in_if.sink    rx,
	escd_out_if.source tx,
	escd_cfg_if.sink   cfg
);

	localparam int FW = $clog2(MAX_CHUNK + 1);
	localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
	localparam int CSW = escd_pkg::CHUNK_SIZE_W;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_FLUSH = 1'b1;

	// Registers
	escd_pkg::byte_t  channel_marker_q;
	escd_pkg::byte_t  escape_marker_q;
	logic [CSW-1:0]   chunk_size_q;

	logic             state_q;
	logic             esc_pend_q;
	logic             chan_pend_q;
	escd_pkg::byte_t  cur_chan_q;
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    rd_idx_q;

	logic             rd_pend_s1;
	logic             rd_last_s1;

	logic             out_valid_q;
	escd_pkg::byte_t  out_chan_q;
	escd_pkg::byte_t  out_byte_q;
	logic             out_last_q;

	// Decode of the incoming word
	logic             accept;
	logic             is_chan;
	logic             is_esc;
	logic             is_data;
	escd_pkg::byte_t  data_byte;
	logic [CSW-1:0]   limit;
	logic             store_en;
	logic [FW-1:0]    fill_new;
	logic             limit_hit;
	logic             flush_go;

	// Flush read side
	logic             issue;
	escd_pkg::byte_t  ram_rdata;

	assign accept    = rx.valid && rx.ready;
	assign rx.ready  = (state_q == ST_IDLE);

	// Channel marker wins over escape marker when both match
	assign is_chan   = (rx.in_byte == channel_marker_q);
	assign is_esc    = !is_chan && (rx.in_byte == escape_marker_q);
	assign is_data   = !is_chan && !is_esc;
	assign data_byte = esc_pend_q ? (rx.in_byte ^ escd_pkg::ESC_FLIP) : rx.in_byte;

	// Zero or oversized chunk size falls back to the full store
	assign limit = ((chunk_size_q == '0) || (chunk_size_q > CSW'(MAX_CHUNK))) ?
		CSW'(MAX_CHUNK) : chunk_size_q;

	assign store_en  = accept && is_data && !chan_pend_q && (fill_q < FW'(MAX_CHUNK));
	assign fill_new  = fill_q + FW'(store_en);
	assign limit_hit = is_data && !chan_pend_q && (CSW'(fill_new) >= limit);
	assign flush_go  = (fill_new != '0) && (is_chan || limit_hit || rx.end_of_payload);

	// One outstanding read; issue only when the output register will be free
	assign issue = (state_q == ST_FLUSH) && !rd_pend_s1 && (rd_idx_q != fill_q) &&
		(!out_valid_q || tx.ready);

	escd_ram #(
		.WIDTH (escd_pkg::BYTE_W),
		.DEPTH (MAX_CHUNK)
	) u_store (
		.clk   (clk),
		.we    (store_en),
		.waddr (fill_q[AW-1:0]),
		.wdata (data_byte),
		.re    (issue),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_marker_q <= escd_pkg::CHANNEL_MARKER_RST;
			escape_marker_q  <= escd_pkg::ESCAPE_MARKER_RST;
			chunk_size_q     <= escd_pkg::CHUNK_SIZE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				escd_pkg::REG_CHANNEL_MARKER: channel_marker_q <= cfg.data;
				escd_pkg::REG_ESCAPE_MARKER:  escape_marker_q  <= cfg.data;
				escd_pkg::REG_CHUNK_SIZE:     chunk_size_q     <= cfg.data[CSW-1:0];
				default: ;
			endcase
		end
	end

	// Decode state and flush sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			esc_pend_q  <= 1'b0;
			chan_pend_q <= 1'b0;
			cur_chan_q  <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			rd_pend_s1  <= 1'b0;
		end else begin
			if (accept) begin
				if (is_chan) begin
					chan_pend_q <= 1'b1;
				end else if (is_esc) begin
					esc_pend_q <= 1'b1;
				end else begin
					esc_pend_q <= 1'b0;
					if (chan_pend_q) begin
						cur_chan_q  <= data_byte;
						chan_pend_q <= 1'b0;
					end
				end
				fill_q   <= fill_new;
				rd_idx_q <= '0;
				if (flush_go) begin
					state_q <= ST_FLUSH;
				end
			end

			if (issue) begin
				rd_idx_q   <= rd_idx_q + FW'(1);
				rd_pend_s1 <= 1'b1;
			end else if (rd_pend_s1) begin
				rd_pend_s1 <= 1'b0;
				// last byte loaded: drop the chunk and reopen rx
				if (rd_last_s1) begin
					state_q  <= ST_IDLE;
					fill_q   <= '0;
					rd_idx_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_last_s1 <= ((rd_idx_q + FW'(1)) == fill_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_chan_q <= cur_chan_q;
			out_byte_q <= ram_rdata;
			out_last_q <= rd_last_s1;
		end
	end

	assign tx.valid      = out_valid_q;
	assign tx.channel    = out_chan_q;
	assign tx.out_byte   = out_byte_q;
	assign tx.chunk_last = out_last_q;

	// A read is only in flight while rx is closed
	a_read_only_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == ST_FLUSH))
		else $error("chunk read outstanding outside flush");

	// Reads never overlap
	a_single_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |=> !rd_pend_s1)
		else $error("back-to-back chunk reads");

	// A new output word only follows a completed read
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rd_pend_s1))
		else $error("output word without chunk read");

	// Read pointer stays inside the chunk
	a_idx_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (rd_idx_q <= fill_q) && (fill_q != '0))
		else $error("flush read pointer beyond chunk");

	// Fill never exceeds the store
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_CHUNK))
		else $error("chunk fill beyond store depth");

endmodule
